// File: src/mid_pkg.sv
package mid_pkg;

  // Width of one lattice vector component in the configuration registers.
  localparam int LAT_W     = 21;
  localparam int CFG_W     = 3 * LAT_W;
  localparam int NAXES     = 3;
  localparam int NCAND     = 27;
  localparam int OUT_W     = 24;
  localparam int TREE_LVLS = 5;
  // Shift index t = (i+1)*9 + (j+1)*3 + (k+1); this one is the unshifted difference.
  localparam int BASE_T    = 13;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_A = 2'd0;
  localparam cfg_idx_t REG_B = 2'd1;
  localparam cfg_idx_t REG_C = 2'd2;

  // Candidate slot n to shift index t. The base sits first so that it wins ties,
  // the shifts follow in ascending order.
  function automatic int shift_code(int n);
    int t;
    if (n == 0) begin
      t = BASE_T;
    end else if (n <= BASE_T) begin
      t = n - 1;
    end else begin
      t = n;
    end
    return t;
  endfunction

endpackage

// File: src/mid_cand.sv
module mid_cand #(
  parameter int CW     = 21,
  parameter int CAND_W = 24
) (
  input  logic                              clk,
  input  logic                              en_base,
  input  logic                              en_cand,
  input  logic signed [CW-1:0]              first_i   [mid_pkg::NAXES],
  input  logic signed [CW-1:0]              second_i  [mid_pkg::NAXES],
  input  logic signed [mid_pkg::LAT_W-1:0]  latt_i    [mid_pkg::NAXES][mid_pkg::NAXES],
  output logic signed [CAND_W-1:0]          cand_o    [mid_pkg::NCAND][mid_pkg::NAXES]
);
  import mid_pkg::*;

  localparam int BASE_W = CW + 1;

  logic signed [BASE_W-1:0] base_r [NAXES];
  logic signed [CAND_W-1:0] cand_r [NCAND][NAXES];

  function automatic logic signed [CAND_W-1:0] apply(int k, logic signed [LAT_W-1:0] v);
    logic signed [CAND_W-1:0] ext;
    ext = CAND_W'(v);
    if (k > 0) return ext;
    else if (k < 0) return -ext;
    else return '0;
  endfunction

  always_ff @(posedge clk) begin
    if (en_base) begin
      for (int c = 0; c < NAXES; c++) begin
        base_r[c] <= BASE_W'(first_i[c]) - BASE_W'(second_i[c]);
      end
    end
  end

  for (genvar n = 0; n < NCAND; n++) begin : g_cand
    localparam int T  = shift_code(n);
    localparam int KA = T / 9 - 1;
    localparam int KB = (T / 3) % 3 - 1;
    localparam int KC = T % 3 - 1;
    for (genvar c = 0; c < NAXES; c++) begin : g_axis
      logic signed [CAND_W-1:0] cand_nxt;
      assign cand_nxt = CAND_W'(base_r[c]) + apply(KA, latt_i[0][c])
                      + apply(KB, latt_i[1][c]) + apply(KC, latt_i[2][c]);
      always_ff @(posedge clk) begin
        if (en_cand) begin
          cand_r[n][c] <= cand_nxt;
        end
      end
      assign cand_o[n][c] = cand_r[n][c];
    end
  end

endmodule

// File: src/mid_norm.sv
module mid_norm #(
  parameter int CAND_W = 24,
  parameter int NORM_W = 49
) (
  input  logic                     clk,
  input  logic                     en_sq,
  input  logic                     en_sum,
  input  logic signed [CAND_W-1:0] cand_i [mid_pkg::NCAND][mid_pkg::NAXES],
  output logic signed [CAND_W-1:0] cand_o [mid_pkg::NCAND][mid_pkg::NAXES],
  output logic [NORM_W-1:0]        norm_o [mid_pkg::NCAND]
);
  import mid_pkg::*;

  localparam int SQ_W = 2 * CAND_W - 1;

  logic [SQ_W-1:0]          sq_r    [NCAND][NAXES];
  logic signed [CAND_W-1:0] cand1_r [NCAND][NAXES];
  logic signed [CAND_W-1:0] cand2_r [NCAND][NAXES];
  logic [NORM_W-1:0]        norm_r  [NCAND];

  for (genvar n = 0; n < NCAND; n++) begin : g_lane
    for (genvar c = 0; c < NAXES; c++) begin : g_axis
      logic signed [2*CAND_W-1:0] prod;
      assign prod = cand_i[n][c] * cand_i[n][c];
      always_ff @(posedge clk) begin
        if (en_sq) begin
          sq_r[n][c]    <= prod[SQ_W-1:0];
          cand1_r[n][c] <= cand_i[n][c];
        end
        if (en_sum) begin
          cand2_r[n][c] <= cand1_r[n][c];
        end
      end
      assign cand_o[n][c] = cand2_r[n][c];
    end
    always_ff @(posedge clk) begin
      if (en_sum) begin
        norm_r[n] <= NORM_W'(sq_r[n][0]) + NORM_W'(sq_r[n][1]) + NORM_W'(sq_r[n][2]);
      end
    end
    assign norm_o[n] = norm_r[n];
  end

endmodule

// File: src/mid_min.sv
module mid_min #(
  parameter int CAND_W = 24,
  parameter int NORM_W = 49
) (
  input  logic                          clk,
  input  logic [mid_pkg::TREE_LVLS-1:0] en_lvl,
  input  logic signed [CAND_W-1:0]      cand_i [mid_pkg::NCAND][mid_pkg::NAXES],
  input  logic [NORM_W-1:0]             norm_i [mid_pkg::NCAND],
  output logic signed [CAND_W-1:0]      best_o [mid_pkg::NAXES]
);
  import mid_pkg::*;

  function automatic int lvl_cnt(int l);
    int k;
    k = NCAND;
    for (int i = 0; i < l; i++) k = (k + 1) >> 1;
    return k;
  endfunction

  // Level 0 is the input; each later level is a register row. Only the first
  // lvl_cnt(l) entries of a row are in use.
  logic signed [CAND_W-1:0] vec_r  [TREE_LVLS+1][NCAND][NAXES];
  logic [NORM_W-1:0]        norm_r [TREE_LVLS+1][NCAND];

  for (genvar n = 0; n < NCAND; n++) begin : g_in
    assign norm_r[0][n] = norm_i[n];
    for (genvar c = 0; c < NAXES; c++) begin : g_axis
      assign vec_r[0][n][c] = cand_i[n][c];
    end
  end

  for (genvar l = 1; l <= TREE_LVLS; l++) begin : g_lvl
    localparam int NIN  = lvl_cnt(l - 1);
    localparam int NOUT = lvl_cnt(l);
    for (genvar m = 0; m < NOUT; m++) begin : g_node
      if (2 * m + 1 < NIN) begin : g_pair
        // The left entry is earlier in the search order and keeps ties.
        logic take_right;
        assign take_right = norm_r[l-1][2*m+1] < norm_r[l-1][2*m];
        always_ff @(posedge clk) begin
          if (en_lvl[l-1]) begin
            norm_r[l][m] <= take_right ? norm_r[l-1][2*m+1] : norm_r[l-1][2*m];
            for (int c = 0; c < NAXES; c++) begin
              vec_r[l][m][c] <= take_right ? vec_r[l-1][2*m+1][c] : vec_r[l-1][2*m][c];
            end
          end
        end
      end else begin : g_pass
        always_ff @(posedge clk) begin
          if (en_lvl[l-1]) begin
            norm_r[l][m] <= norm_r[l-1][2*m];
            for (int c = 0; c < NAXES; c++) begin
              vec_r[l][m][c] <= vec_r[l-1][2*m][c];
            end
          end
        end
      end
    end
  end

  for (genvar c = 0; c < NAXES; c++) begin : g_out
    assign best_o[c] = vec_r[TREE_LVLS][0][c];
  end

endmodule

// File: src/minimum_image_displacement.sv
// Minimum-image displacement for a triclinic cell. Each input beat carries two
// positions; the block forms first minus second, adds all 26 combinations of
// -1, 0, +1 times the three lattice vectors, and returns the candidate with the
// smallest squared length (the unshifted difference wins ties, then the earliest
// shift with the a vector outermost). One beat is accepted every clock cycle
// while the input is not stalled. A beat passes two adder stages, a squaring
// stage, a summing stage, a five-level registered minimum tree and the output
// register with saturation to 24 bits. Backpressure fills bubbles before it
// stalls the input. The user must write lattice registers through the cfg port
// only while no beat is in flight; the block itself does not enforce this.
module minimum_image_displacement #(
  parameter int COORD_WIDTH = 21
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, zero fill
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // delta_x, delta_y, delta_z
  output logic [3*mid_pkg::OUT_W-1:0]            out_tdata,
  input  logic                                   cfg_we,
  input  mid_pkg::cfg_idx_t                      cfg_index,
  input  logic [mid_pkg::CFG_W-1:0]              cfg_data
);
  import mid_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int WIDER  = (CW + 1 > LAT_W) ? CW + 1 : LAT_W;
  localparam int CAND_W = WIDER + 2;
  localparam int NORM_W = 2 * CAND_W + 1;
  localparam int NST    = 4 + TREE_LVLS + 1;

  logic [CFG_W-1:0]         latt_r [NAXES];
  logic signed [LAT_W-1:0]  latt   [NAXES][NAXES];
  logic signed [CW-1:0]     first  [NAXES];
  logic signed [CW-1:0]     second [NAXES];
  logic signed [CAND_W-1:0] cand   [NCAND][NAXES];
  logic signed [CAND_W-1:0] cand_n [NCAND][NAXES];
  logic [NORM_W-1:0]        norm   [NCAND];
  logic signed [CAND_W-1:0] best   [NAXES];
  logic [NST-1:0]           vld_r;
  logic [NST-1:0]           en;
  logic [OUT_W-1:0]         out_r  [NAXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < NAXES; v++) latt_r[v] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_A:   latt_r[0] <= cfg_data;
        REG_B:   latt_r[1] <= cfg_data;
        REG_C:   latt_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar v = 0; v < NAXES; v++) begin : g_latt
    for (genvar c = 0; c < NAXES; c++) begin : g_comp
      assign latt[v][c] = latt_r[v][c*LAT_W +: LAT_W];
    end
  end

  for (genvar c = 0; c < NAXES; c++) begin : g_in
    assign first[c]  = in_tdata[c*CW +: CW];
    assign second[c] = in_tdata[(c+3)*CW +: CW];
  end

  // A stage takes new data when it is empty or its successor moves on.
  always_comb begin
    en[NST-1] = !vld_r[NST-1] || out_tready;
    for (int s = NST - 2; s >= 0; s--) begin
      en[s] = !vld_r[s] || en[s+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_tvalid;
      for (int s = 1; s < NST; s++) begin
        if (en[s]) vld_r[s] <= vld_r[s-1];
      end
    end
  end

  mid_cand #(.CW(CW), .CAND_W(CAND_W)) u_cand (
    .clk      (clk),
    .en_base  (en[0]),
    .en_cand  (en[1]),
    .first_i  (first),
    .second_i (second),
    .latt_i   (latt),
    .cand_o   (cand)
  );

  mid_norm #(.CAND_W(CAND_W), .NORM_W(NORM_W)) u_norm (
    .clk    (clk),
    .en_sq  (en[2]),
    .en_sum (en[3]),
    .cand_i (cand),
    .cand_o (cand_n),
    .norm_o (norm)
  );

  mid_min #(.CAND_W(CAND_W), .NORM_W(NORM_W)) u_min (
    .clk    (clk),
    .en_lvl (en[4 +: TREE_LVLS]),
    .cand_i (cand_n),
    .norm_i (norm),
    .best_o (best)
  );

  for (genvar c = 0; c < NAXES; c++) begin : g_out
    logic [OUT_W-1:0] out_nxt;
    if (CAND_W <= OUT_W) begin : g_ext
      assign out_nxt = OUT_W'(best[c]);
    end else begin : g_sat
      localparam logic signed [CAND_W-1:0] HI = CAND_W'((64'sd1 <<< (OUT_W - 1)) - 1);
      localparam logic signed [CAND_W-1:0] LO = -CAND_W'(64'sd1 <<< (OUT_W - 1));
      always_comb begin
        priority if (best[c] > HI) out_nxt = HI[OUT_W-1:0];
        else if (best[c] < LO)     out_nxt = LO[OUT_W-1:0];
        else                       out_nxt = best[c][OUT_W-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en[NST-1]) out_r[c] <= out_nxt;
    end
    assign out_tdata[c*OUT_W +: OUT_W] = out_r[c];
  end

  assign out_tvalid = vld_r[NST-1];

  a_stall_only_from_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted beat did not enter the first stage");

  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (vld_r == '0))
    else $error("pipeline not empty after reset");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mid_pkg::*;

  localparam int CW = 21;
  localparam int IN_W = ((6 * CW + 7) / 8) * 8;
  localparam int LATENCY = 10;

  typedef struct packed {
    logic signed [OUT_W-1:0] dz;
    logic signed [OUT_W-1:0] dy;
    logic signed [OUT_W-1:0] dx;
  } delta_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [3*OUT_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = REG_A;
  logic [CFG_W-1:0] cfg_data = '0;

  minimum_image_displacement #(.COORD_WIDTH(CW)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Lattice copy: [vector][axis].
  longint lattice [3][3];
  logic [IN_W-1:0] pending_pairs [$];
  delta_t expected_deltas [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit failed = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint lat_comp(logic [CFG_W-1:0] v, int c);
    logic signed [LAT_W-1:0] s;
    s = v[c*LAT_W +: LAT_W];
    return longint'(s);
  endfunction

  function automatic longint sq_len(longint d [3]);
    return d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // Shortest periodic image of first minus second; base wins ties.
  function automatic delta_t nearest_image(logic [IN_W-1:0] pair);
    longint base [3];
    longint best [3];
    longint cand [3];
    longint best_n;
    longint n;
    logic signed [CW-1:0] f;
    logic signed [CW-1:0] s;
    delta_t r;
    for (int c = 0; c < 3; c++) begin
      f = pair[c*CW +: CW];
      s = pair[(c+3)*CW +: CW];
      base[c] = longint'(f) - longint'(s);
      best[c] = base[c];
    end
    best_n = sq_len(best);
    for (int i = -1; i <= 1; i++)
      for (int j = -1; j <= 1; j++)
        for (int k = -1; k <= 1; k++) begin
          if (i == 0 && j == 0 && k == 0) continue;
          for (int c = 0; c < 3; c++)
            cand[c] = base[c] + i * lattice[0][c] + j * lattice[1][c] + k * lattice[2][c];
          n = sq_len(cand);
          if (n < best_n) begin
            best_n = n;
            best = cand;
          end
        end
    r.dx = OUT_W'(clamp24(best[0]));
    r.dy = OUT_W'(clamp24(best[1]));
    r.dz = OUT_W'(clamp24(best[2]));
    return r;
  endfunction

  // Driver.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_pairs.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Prediction at input acceptance, checking at output acceptance.
  always @(posedge clk) begin
    delta_t got;
    delta_t exp_d;
    if (rst_n && in_tvalid && in_tready)
      expected_deltas.push_back(nearest_image(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_deltas.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        failed = 1;
      end else begin
        exp_d = expected_deltas.pop_front();
        if (got.dx !== exp_d.dx) begin
          $display("%0t: delta_x expected %0d actual %0d", $time, exp_d.dx, got.dx);
          failed = 1;
        end
        if (got.dy !== exp_d.dy) begin
          $display("%0t: delta_y expected %0d actual %0d", $time, exp_d.dy, got.dy);
          failed = 1;
        end
        if (got.dz !== exp_d.dz) begin
          $display("%0t: delta_z expected %0d actual %0d", $time, exp_d.dz, got.dz);
          failed = 1;
        end
      end
    end
  end

  function automatic logic [CFG_W-1:0] pack_vec(longint x, longint y, longint z);
    logic [CFG_W-1:0] v;
    v[0 +: LAT_W] = x[LAT_W-1:0];
    v[LAT_W +: LAT_W] = y[LAT_W-1:0];
    v[2*LAT_W +: LAT_W] = z[LAT_W-1:0];
    return v;
  endfunction

  task automatic write_lattice(cfg_idx_t idx, logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    for (int c = 0; c < 3; c++) lattice[idx][c] = lat_comp(v, c);
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || in_tvalid || expected_deltas.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Uniform value in -span .. span.
  function automatic longint rand_comp(int span);
    return longint'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic logic [IN_W-1:0] rand_pair(int span);
    logic [IN_W-1:0] p;
    p = '0;
    for (int c = 0; c < 6; c++) begin
      if (span == 0) p[c*CW +: CW] = CW'($urandom);
      else p[c*CW +: CW] = CW'(rand_comp(span));
    end
    return p;
  endfunction

  function automatic logic [CFG_W-1:0] rand_vec(int span);
    if (span == 0) return CFG_W'({$urandom, $urandom});
    return pack_vec(rand_comp(span), rand_comp(span), rand_comp(span));
  endfunction

  initial begin
    logic [IN_W-1:0] p;
    int spans [4];
    spans = '{0, 40000, 4000, 300000};
    for (int v = 0; v < 3; v++)
      for (int c = 0; c < 3; c++) lattice[v][c] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero lattice, coordinate extremes.
    for (int c = 0; c < 6; c++) begin
      p = '0;
      p[c*CW +: CW] = 21'h100000;
      pending_pairs.push_back(p);
      p[c*CW +: CW] = 21'h0FFFFF;
      pending_pairs.push_back(p);
    end
    pending_pairs.push_back({IN_W{1'b1}} >> (IN_W - 6 * CW));
    drain();

    // Extreme lattice values plus a cubic box with tie cases.
    write_lattice(REG_A, pack_vec(-1048576, -1048576, -1048576));
    write_lattice(REG_B, pack_vec(1048575, 1048575, 1048575));
    write_lattice(REG_C, pack_vec(1048575, -1048576, 0));
    for (int n = 0; n < 4; n++) pending_pairs.push_back(rand_pair(0));
    p = '0;
    p[0 +: CW] = 21'h100000;
    p[3*CW +: CW] = 21'h0FFFFF;
    pending_pairs.push_back(p);
    drain();
    write_lattice(REG_A, pack_vec(2000, 0, 0));
    write_lattice(REG_B, pack_vec(0, 2000, 0));
    write_lattice(REG_C, pack_vec(0, 0, 2000));
    // Exactly half a box apart: base ties with a shift.
    p = '0;
    p[0 +: CW] = CW'(1000);
    pending_pairs.push_back(p);
    p[CW +: CW] = -21'sd1000;
    pending_pairs.push_back(p);
    p = '0;
    p[0 +: CW] = CW'(1500);
    p[2*CW +: CW] = -21'sd1700;
    pending_pairs.push_back(p);
    drain();

    // Random phases over idle/stall profiles and lattice settings.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      write_lattice(REG_A, rand_vec(spans[ph % 4]));
      write_lattice(REG_B, rand_vec(spans[(ph + 1) % 4]));
      write_lattice(REG_C, rand_vec(spans[ph % 4]));
      for (int n = 0; n < 85; n++)
        pending_pairs.push_back(rand_pair(n % 3 == 0 ? 0 : spans[(ph + n) % 4] / 2 + 1));
      if (ph == 4) begin
        // Hold off the sender until the pipeline has fully emptied.
        while (pending_pairs.size() > 40) @(posedge clk);
        send_idle_pct = 100;
        while (expected_deltas.size() > 0 || in_tvalid) @(posedge clk);
        send_idle_pct = 0;
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
src/mid_pkg.sv
src/mid_cand.sv
src/mid_norm.sv
src/mid_min.sv
src/minimum_image_displacement.sv
verif/testbench.sv
